FILE: rtl/sskl_pkg.sv
// sskl_pkg: shared types and codes of the stable sorted key list unit
// operation codes, result status codes and the compare result struct
// no dependencies
package sskl_pkg;

  localparam int TAG_W     = 6;
  localparam int TAG_SLOTS = 64;

  typedef enum logic [1:0] {
    FUNC_INSERT  = 2'd0,
    FUNC_REM_TAG = 2'd1,
    FUNC_REM_POS = 2'd2,
    FUNC_UPDATE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_NO_TAG    = 3'd2,
    STAT_POS_RANGE = 3'd3,
    STAT_DUP_TAG   = 3'd4
  } status_t;

  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_res_t;

endpackage

FILE: rtl/sskl_cmp.sv
// sskl_cmp: the one signed key comparator, shared by the insert walk and the update key check
// uses sskl_pkg for the compare result struct
module sskl_cmp #(
  parameter int KEY_BITS = 16
) (
  input  logic signed [KEY_BITS-1:0] key_a,
  input  logic signed [KEY_BITS-1:0] key_b,
  output sskl_pkg::cmp_res_t         res
);

  // a greater than b, and a equal to b
  assign res.gt = (key_a > key_b);
  assign res.eq = (key_a == key_b);

endmodule

FILE: rtl/sskl_store.sv
// sskl_store: key and tag memories indexed by position, and the tag to position map
// one write and one registered read per memory per cycle; uses sskl_pkg for tag width
module sskl_store #(
  parameter int  CAPACITY = 64,
  parameter int  KEY_BITS = 16,
  localparam int AW       = $clog2(CAPACITY)
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [AW-1:0]                     wr_addr,
  input  logic signed [KEY_BITS-1:0]        wr_key,
  input  logic [sskl_pkg::TAG_W-1:0]        wr_tag,
  input  logic [AW-1:0]                     rd_addr,
  output logic signed [KEY_BITS-1:0]        rd_key,
  output logic [sskl_pkg::TAG_W-1:0]        rd_tag,
  input  logic                              pot_we,
  input  logic [sskl_pkg::TAG_W-1:0]        pot_wr_addr,
  input  logic [AW-1:0]                     pot_wr_data,
  input  logic [sskl_pkg::TAG_W-1:0]        pot_rd_addr,
  output logic [AW-1:0]                     pot_rd_data
);

  logic signed [KEY_BITS-1:0]       key_mem [CAPACITY];
  logic [sskl_pkg::TAG_W-1:0]       tag_mem [CAPACITY];
  logic [AW-1:0]                    pot_mem [sskl_pkg::TAG_SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      tag_mem[wr_addr] <= wr_tag;
    end
    rd_key <= key_mem[rd_addr];
    rd_tag <= tag_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pot_we) begin
      pot_mem[pot_wr_addr] <= pot_wr_data;
    end
    pot_rd_data <= pot_mem[pot_rd_addr];
  end

endmodule

FILE: rtl/stable_sorted_key_list_unit.sv
// stable_sorted_key_list_unit: sorted list of tagged entries with a tag to position map
// operations: insert walks down from the tail to its place, removes close the gap above the
// removed position, failed operations go straight to the result, and update keeps an unchanged
// key in place or else removes and reinserts the entry; one operation at a time, in_stall is
// high from acceptance until the result beat enters the output register
// reset: synchronous active low, clears the valid-tag map, occupancy and control; memories unreset
module stable_sorted_key_list_unit #(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [5:0]  in_tag,
  input  logic signed [15:0] in_key,
  input  logic [5:0]  in_position,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [5:0]  out_placed_at,
  output logic [6:0]  out_occupancy,
  output logic [5:0]  out_removed_tag
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 6) ? CW : 6;
  localparam int TW = sskl_pkg::TAG_W;

  // sequencer states, one-hot
  typedef enum logic [8:0] {
    ST_IDLE      = 9'b000000001,
    ST_INS_START = 9'b000000010,
    ST_INS_STEP  = 9'b000000100,
    ST_INS_PLACE = 9'b000001000,
    ST_POT_RD    = 9'b000010000,
    ST_TAG_RD    = 9'b000100000,
    ST_KEY_CHK   = 9'b001000000,
    ST_RM_STEP   = 9'b010000000,
    ST_RESULT    = 9'b100000000
  } state_t;

  state_t                     state_r, state_nxt;
  sskl_pkg::func_t            op_r, op_nxt;
  logic [TW-1:0]              tag_r, tag_nxt;
  logic signed [KEY_BITS-1:0] key_r, key_nxt;
  logic [AW-1:0]              idx_r, idx_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  sskl_pkg::status_t          status_r, status_nxt;
  logic [AW-1:0]              placed_r, placed_nxt;
  logic [TW-1:0]              removed_r, removed_nxt;
  logic [sskl_pkg::TAG_SLOTS-1:0] tag_valid_r, tag_valid_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [2:0]                 out_status_r;
  logic [5:0]                 out_placed_r;
  logic [6:0]                 out_occ_r;
  logic [5:0]                 out_removed_r;
  logic                       out_load;

  // memory side
  logic                       mem_we;
  logic [AW-1:0]              wr_addr;
  logic signed [KEY_BITS-1:0] wr_key;
  logic [TW-1:0]              wr_tag;
  logic [AW-1:0]              rd_addr;
  logic signed [KEY_BITS-1:0] rd_key;
  logic [TW-1:0]              rd_tag;
  logic                       pot_we;
  logic [TW-1:0]              pot_wr_addr;
  logic [AW-1:0]              pot_wr_data;
  logic [AW-1:0]              pot_rd;

  sskl_pkg::cmp_res_t         cmp;

  // remove walk start, shared by the three ways into a removal
  logic                       rm_go;
  logic [AW-1:0]              rm_p;
  logic                       rm_last;
  // new entry written at idx
  logic                       place_go;

  sskl_store #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_store (
    .clk         (clk),
    .wr_en       (mem_we),
    .wr_addr     (wr_addr),
    .wr_key      (wr_key),
    .wr_tag      (wr_tag),
    .rd_addr     (rd_addr),
    .rd_key      (rd_key),
    .rd_tag      (rd_tag),
    .pot_we      (pot_we),
    .pot_wr_addr (pot_wr_addr),
    .pot_wr_data (pot_wr_data),
    .pot_rd_addr (in_tag),
    .pot_rd_data (pot_rd)
  );

  // the stored key just read against the operation's key
  sskl_cmp #(
    .KEY_BITS (KEY_BITS)
  ) u_cmp (
    .key_a (rd_key),
    .key_b (key_r),
    .res   (cmp)
  );

  assign in_stall = (state_r != ST_IDLE);

  // the map read returns the position in the cycle after acceptance
  assign rm_p    = (state_r == ST_POT_RD) ? pot_rd : idx_r;
  assign rm_last = ((CW'(rm_p) + CW'(1)) >= count_r);

  assign out_load = (state_r == ST_RESULT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    tag_nxt       = tag_r;
    key_nxt       = key_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    status_nxt    = status_r;
    placed_nxt    = placed_r;
    removed_nxt   = removed_r;
    tag_valid_nxt = tag_valid_r;
    rd_addr       = idx_r;
    mem_we        = 1'b0;
    wr_addr       = idx_r;
    wr_key        = rd_key;
    wr_tag        = rd_tag;
    pot_we        = 1'b0;
    pot_wr_addr   = rd_tag;
    pot_wr_data   = idx_r;
    rm_go         = 1'b0;
    place_go      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt      = sskl_pkg::func_t'(in_func);
          tag_nxt     = in_tag;
          key_nxt     = KEY_BITS'(in_key);
          status_nxt  = sskl_pkg::STAT_OK;
          placed_nxt  = '0;
          removed_nxt = '0;
          case (sskl_pkg::func_t'(in_func))
            sskl_pkg::FUNC_INSERT: begin
              if (tag_valid_r[in_tag]) begin
                status_nxt = sskl_pkg::STAT_DUP_TAG;
                state_nxt  = ST_RESULT;
              end else if (count_r == CW'(CAPACITY)) begin
                status_nxt = sskl_pkg::STAT_FULL;
                state_nxt  = ST_RESULT;
              end else begin
                state_nxt = ST_INS_START;
              end
            end
            sskl_pkg::FUNC_REM_TAG: begin
              if (!tag_valid_r[in_tag]) begin
                status_nxt = sskl_pkg::STAT_NO_TAG;
                state_nxt  = ST_RESULT;
              end else begin
                tag_valid_nxt[in_tag] = 1'b0;
                removed_nxt           = in_tag;
                state_nxt             = ST_POT_RD;
              end
            end
            sskl_pkg::FUNC_REM_POS: begin
              if (PW'(in_position) >= PW'(count_r)) begin
                status_nxt = sskl_pkg::STAT_POS_RANGE;
                state_nxt  = ST_RESULT;
              end else begin
                rd_addr   = AW'(in_position);
                idx_nxt   = AW'(in_position);
                state_nxt = ST_TAG_RD;
              end
            end
            sskl_pkg::FUNC_UPDATE: begin
              if (!tag_valid_r[in_tag]) begin
                status_nxt = sskl_pkg::STAT_NO_TAG;
                state_nxt  = ST_RESULT;
              end else begin
                state_nxt = ST_POT_RD;
              end
            end
            default: begin
              state_nxt = ST_RESULT;
            end
          endcase
        end
      end

      // walk down from the tail, insert point is after the last key <= new key
      ST_INS_START: begin
        idx_nxt = AW'(count_r);
        if (count_r == '0) begin
          state_nxt = ST_INS_PLACE;
        end else begin
          rd_addr   = AW'(count_r - CW'(1));
          state_nxt = ST_INS_STEP;
        end
      end

      ST_INS_STEP: begin
        if (cmp.gt) begin
          // move entry idx-1 up one slot
          mem_we      = 1'b1;
          pot_we      = 1'b1;
          pot_wr_addr = rd_tag;
          if (idx_r == AW'(1)) begin
            idx_nxt   = '0;
            state_nxt = ST_INS_PLACE;
          end else begin
            idx_nxt = idx_r - AW'(1);
            rd_addr = idx_r - AW'(1) - AW'(1);
          end
        end else begin
          place_go = 1'b1;
        end
      end

      ST_INS_PLACE: begin
        place_go = 1'b1;
      end

      ST_POT_RD: begin
        idx_nxt = pot_rd;
        if (op_r == sskl_pkg::FUNC_UPDATE) begin
          rd_addr   = pot_rd;
          state_nxt = ST_KEY_CHK;
        end else begin
          rm_go = 1'b1;
        end
      end

      ST_TAG_RD: begin
        removed_nxt           = rd_tag;
        tag_valid_nxt[rd_tag] = 1'b0;
        rm_go                 = 1'b1;
      end

      ST_KEY_CHK: begin
        if (cmp.eq) begin
          // unchanged key leaves the entry where it is
          placed_nxt = idx_r;
          state_nxt  = ST_RESULT;
        end else begin
          rm_go = 1'b1;
        end
      end

      // close the gap: entry idx+1 moves down to idx
      ST_RM_STEP: begin
        mem_we      = 1'b1;
        pot_we      = 1'b1;
        pot_wr_addr = rd_tag;
        if ((CW'(idx_r) + CW'(2)) < count_r) begin
          idx_nxt = idx_r + AW'(1);
          rd_addr = idx_r + AW'(1) + AW'(1);
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = (op_r == sskl_pkg::FUNC_UPDATE) ? ST_INS_START : ST_RESULT;
        end
      end

      ST_RESULT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (rm_go) begin
      idx_nxt    = rm_p;
      placed_nxt = rm_p;
      if (rm_last) begin
        count_nxt = count_r - CW'(1);
        state_nxt = (op_r == sskl_pkg::FUNC_UPDATE) ? ST_INS_START : ST_RESULT;
      end else begin
        rd_addr   = rm_p + AW'(1);
        state_nxt = ST_RM_STEP;
      end
    end

    if (place_go) begin
      mem_we                = 1'b1;
      wr_key                = key_r;
      wr_tag                = tag_r;
      pot_we                = 1'b1;
      pot_wr_addr           = tag_r;
      tag_valid_nxt[tag_r]  = 1'b1;
      count_nxt             = count_r + CW'(1);
      placed_nxt            = idx_r;
      state_nxt             = ST_RESULT;
    end
  end

  // output register parts the result side from the sequencer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      tag_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      tag_valid_r <= tag_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    tag_r     <= tag_nxt;
    key_r     <= key_nxt;
    idx_r     <= idx_nxt;
    status_r  <= status_nxt;
    placed_r  <= placed_nxt;
    removed_r <= removed_nxt;
    if (out_load) begin
      out_status_r  <= status_r;
      out_placed_r  <= 6'(placed_r);
      out_occ_r     <= 7'(count_r);
      out_removed_r <= removed_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_placed_at   = out_placed_r;
  assign out_occupancy   = out_occ_r;
  assign out_removed_tag = out_removed_r;

endmodule

FILE: rtl/sskl_chk.sv
// sskl_chk: port-level checks of the stable sorted key list unit, bound to the top level
// uses sskl_pkg for status codes
module sskl_chk #(
  parameter int CAPACITY = 64
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_status,
  input logic [5:0] out_placed_at,
  input logic [6:0] out_occupancy,
  input logic [5:0] out_removed_tag
);

  // an accepted beat makes the unit busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accepted beat");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_placed_at)
      && $stable(out_occupancy) && $stable(out_removed_tag))
    else $error("stalled result beat changed");

  // failed operations report zero position and tag
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != sskl_pkg::STAT_OK) |->
      (out_placed_at == 6'd0) && (out_removed_tag == 6'd0))
    else $error("failed operation with nonzero position or tag");

  // full status only with the list at capacity
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == sskl_pkg::STAT_FULL) |-> (out_occupancy == 7'(CAPACITY)))
    else $error("full status below capacity");

  // failed inserts never report a removed tag
  a_no_stray_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status == sskl_pkg::STAT_DUP_TAG) || (out_status == sskl_pkg::STAT_FULL))
      |-> (out_removed_tag == 6'd0))
    else $error("insert failure with removed tag");

endmodule

bind stable_sorted_key_list_unit sskl_chk #(
  .CAPACITY (CAPACITY)
) u_sskl_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_placed_at   (out_placed_at),
  .out_occupancy   (out_occupancy),
  .out_removed_tag (out_removed_tag)
);
